@@ rtl/core/bngc_pkg.sv @@
// Shared types and constants for the bitonic network comparator generator.
// Holds the frame layout, the frame kinds and the split-point function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bngc_pkg;

    localparam int MAX_WIRES   = 1024;
    localparam int FRAME_DEPTH = 21;

    localparam int WIRE_W = 10;
    localparam int LEN_W  = 11;
    localparam int SP_W   = 5;
    localparam int ADDR_W = 5;

    localparam logic [LEN_W-1:0] MAX_WIRES_L = LEN_W'(MAX_WIRES);

    typedef enum logic [1:0] {
        KIND_SORT,
        KIND_MERGE,
        KIND_LOOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [WIRE_W-1:0]  lo;
        logic [LEN_W-1:0]   len;
        logic               asc;
    } frame_t;

    // Largest power of two strictly below len (len >= 2).
    function automatic logic [LEN_W-1:0] split_point(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m;
        logic [LEN_W-1:0] p;
        m = len - LEN_W'(1);
        p = '0;
        for (int b = 0; b < LEN_W; b++)
        begin
            if (m[b])
            begin
                p = LEN_W'(1) << b;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bitonic_network_comparator_generator.sv @@
// Bitonic network comparator generator, top level.
// Walk: each request fetches frames through the frame memory's single read and write port;
// an expanded frame is replaced by at most 3 pushed frames until a loop frame is on top.
// Requests are taken one at a time, only in the idle state; each yields one comparator transfer.
// Reset: stack empty, nothing pending, network_size 0; frame memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bitonic_network_comparator_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [10:0]                 cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        restart,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bngc_pkg::WIRE_W-1:0]      min_wire,
    output logic [bngc_pkg::WIRE_W-1:0]      max_wire,
    output logic                             final_gate,
    output logic                             none_left
);
    import bngc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_FETCH,
        ST_EVAL,
        ST_PUSH
    } state_t;

    state_t             state_reg;
    logic [LEN_W-1:0]   network_size_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [WIRE_W-1:0]  idx_reg;
    logic               done_reg;
    frame_t             top_reg;
    frame_t             push_reg [3];
    logic [1:0]         push_cnt_reg;
    logic [1:0]         push_step_reg;

    logic               out_valid_reg;
    logic [WIRE_W-1:0]  min_wire_reg;
    logic [WIRE_W-1:0]  max_wire_reg;
    logic               final_gate_reg;
    logic               none_left_reg;

    frame_t             mem [FRAME_DEPTH];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    frame_t             mem_wdata;

    logic               accept;
    logic               slot_free;
    logic               out_load;
    logic [LEN_W-1:0]   n_sat;
    logic [LEN_W-1:0]   k;
    logic [LEN_W-1:0]   rest;
    logic               has_r;
    logic               has_l;
    frame_t             fr_left;
    frame_t             fr_right;
    frame_t             fr_self;
    frame_t             list0;
    frame_t             list1;
    frame_t             list2;
    logic [1:0]         cnt;
    logic [SP_W:0]      depth_after;
    logic [LEN_W-1:0]   wi;
    logic [LEN_W-1:0]   wj;
    logic [LEN_W-1:0]   idx_inc;
    logic               loop_end;
    logic [SP_W-1:0]    sp_dec;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign out_load   = slot_free && ((state_reg == ST_EMPTY) ||
                        ((state_reg == ST_EVAL) && (top_reg.kind == KIND_LOOP)));
    assign out_valid  = out_valid_reg;
    assign min_wire   = min_wire_reg;
    assign max_wire   = max_wire_reg;
    assign final_gate = final_gate_reg;
    assign none_left  = none_left_reg;

    assign n_sat  = (network_size_reg > MAX_WIRES_L) ? MAX_WIRES_L : network_size_reg;
    assign sp_dec = sp_reg - SP_W'(1);

    always_comb
    begin
        k        = split_point(top_reg.len);
        rest     = top_reg.len - k;
        has_r    = rest > LEN_W'(1);
        has_l    = k > LEN_W'(1);
        fr_self  = top_reg;
        fr_right = top_reg;
        fr_left  = top_reg;
        fr_right.lo  = top_reg.lo + k[WIRE_W-1:0];
        fr_right.len = rest;
        fr_left.len  = k;
        if (top_reg.kind == KIND_SORT)
        begin
            fr_self.kind  = KIND_MERGE;
            fr_right.kind = KIND_SORT;
            fr_left.kind  = KIND_SORT;
            fr_left.asc   = !top_reg.asc;
            list0 = fr_self;
            list1 = has_r ? fr_right : fr_left;
            list2 = fr_left;
        end
        else
        begin
            fr_self.kind  = KIND_LOOP;
            fr_right.kind = KIND_MERGE;
            fr_left.kind  = KIND_MERGE;
            list0 = has_r ? fr_right : (has_l ? fr_left : fr_self);
            list1 = (has_r && has_l) ? fr_left : fr_self;
            list2 = fr_self;
        end
        cnt         = 2'd1 + {1'b0, has_r} + {1'b0, has_l};
        depth_after = {1'b0, sp_dec} + {{(SP_W-1){1'b0}}, cnt};

        wi       = {1'b0, top_reg.lo} + {1'b0, idx_reg};
        wj       = wi + k;
        idx_inc  = {1'b0, idx_reg} + LEN_W'(1);
        loop_end = idx_inc >= rest;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = push_reg[push_step_reg];
        if (accept && restart && (n_sat > LEN_W'(1)))
        begin
            mem_we         = 1'b1;
            mem_wdata.kind = KIND_SORT;
            mem_wdata.lo   = '0;
            mem_wdata.len  = n_sat;
            mem_wdata.asc  = 1'b1;
        end
        else if (state_reg == ST_PUSH)
        begin
            mem_we    = 1'b1;
            mem_waddr = sp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_FETCH)
        begin
            top_reg <= mem[sp_dec];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            network_size_reg <= '0;
            sp_reg           <= '0;
            idx_reg          <= '0;
            done_reg         <= 1'b1;
            push_cnt_reg     <= '0;
            push_step_reg    <= '0;
            out_valid_reg    <= 1'b0;
            min_wire_reg     <= '0;
            max_wire_reg     <= '0;
            final_gate_reg   <= 1'b0;
            none_left_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                network_size_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (restart)
                        begin
                            idx_reg <= '0;
                            if (n_sat > LEN_W'(1))
                            begin
                                sp_reg    <= SP_W'(1);
                                done_reg  <= 1'b0;
                                state_reg <= ST_FETCH;
                            end
                            else
                            begin
                                sp_reg    <= '0;
                                done_reg  <= 1'b1;
                                state_reg <= ST_EMPTY;
                            end
                        end
                        else if (done_reg || sp_reg == '0)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end

                ST_EMPTY:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        min_wire_reg   <= '0;
                        max_wire_reg   <= '0;
                        final_gate_reg <= 1'b0;
                        none_left_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                ST_FETCH:
                begin
                    state_reg <= ST_EVAL;
                end

                ST_EVAL:
                begin
                    if (top_reg.kind == KIND_LOOP)
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            none_left_reg <= 1'b0;
                            if (top_reg.asc)
                            begin
                                min_wire_reg <= wi[WIRE_W-1:0];
                                max_wire_reg <= wj[WIRE_W-1:0];
                            end
                            else
                            begin
                                min_wire_reg <= wj[WIRE_W-1:0];
                                max_wire_reg <= wi[WIRE_W-1:0];
                            end
                            if (loop_end)
                            begin
                                idx_reg        <= '0;
                                sp_reg         <= sp_dec;
                                final_gate_reg <= (sp_dec == '0);
                                if (sp_dec == '0)
                                begin
                                    done_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                idx_reg        <= idx_inc[WIRE_W-1:0];
                                final_gate_reg <= 1'b0;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (depth_after > (SP_W+1)'(FRAME_DEPTH))
                    begin
                        // stack overflow ends the walk
                        sp_reg    <= '0;
                        idx_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        sp_reg        <= sp_dec;
                        push_reg[0]   <= list0;
                        push_reg[1]   <= list1;
                        push_reg[2]   <= list2;
                        push_cnt_reg  <= cnt;
                        push_step_reg <= '0;
                        state_reg     <= ST_PUSH;
                    end
                end

                ST_PUSH:
                begin
                    sp_reg <= sp_reg + SP_W'(1);
                    if (push_step_reg == push_cnt_reg - 2'd1)
                    begin
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        push_step_reg <= push_step_reg + 2'd1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for the bitonic network comparator generator.
// Mirrors the frame walk in plain SystemVerilog and checks every comparator transfer.
// Depends on bngc_pkg and bitonic_network_comparator_generator.
`timescale 1ns / 1ps

module tb;

    import bngc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct {
        logic [WIRE_W-1:0] min_w;
        logic [WIRE_W-1:0] max_w;
        logic              fin;
        logic              none;
    } gate_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [10:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                restart = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [WIRE_W-1:0]   min_wire;
    logic [WIRE_W-1:0]   max_wire;
    logic                final_gate;
    logic                none_left;

    // predictor state
    frame_t              walk_frames [FRAME_DEPTH];
    logic [SP_W-1:0]     walk_depth = '0;
    logic [WIRE_W-1:0]   loop_pos = '0;
    logic                walk_idle = 1'b1;
    logic [LEN_W-1:0]    size_reg = '0;

    gate_t               expected_gates [$];
    gate_t               want_gate;
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  sent_count = 0;
    int                  holdoff_left = 0;
    bit                  quiet = 1'b0;

    bitonic_network_comparator_generator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .min_wire   (min_wire),
        .max_wire   (max_wire),
        .final_gate (final_gate),
        .none_left  (none_left)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_gates.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // largest power of two strictly below len
    function automatic int half_span(input int len);
        int p;
        p = 1;
        while (p < len)
            p = p << 1;
        return p >> 1;
    endfunction

    function automatic bit push_walk_frame(input kind_t kd, input int lo, input int len,
                                           input logic asc);
        if (walk_depth >= FRAME_DEPTH)
            return 1'b0;
        walk_frames[walk_depth] = '{kd, WIRE_W'(lo), LEN_W'(len), asc};
        walk_depth++;
        return 1'b1;
    endfunction

    function automatic bit expand_walk();
        frame_t f;
        int     k;
        bit     ok;
        while (walk_depth > 0 && walk_frames[walk_depth - 1].kind != KIND_LOOP)
        begin
            f = walk_frames[walk_depth - 1];
            k = half_span(int'(f.len));
            ok = 1'b1;
            walk_depth--;
            if (f.kind == KIND_SORT)
            begin
                ok = ok && push_walk_frame(KIND_MERGE, f.lo, f.len, f.asc);
                if (int'(f.len) - k > 1)
                    ok = ok && push_walk_frame(KIND_SORT, f.lo + k, int'(f.len) - k, f.asc);
                if (k > 1)
                    ok = ok && push_walk_frame(KIND_SORT, f.lo, k, !f.asc);
            end
            else
            begin
                if (int'(f.len) - k > 1)
                    ok = ok && push_walk_frame(KIND_MERGE, f.lo + k, int'(f.len) - k, f.asc);
                if (k > 1)
                    ok = ok && push_walk_frame(KIND_MERGE, f.lo, k, f.asc);
                ok = ok && push_walk_frame(KIND_LOOP, f.lo, f.len, f.asc);
            end
            if (!ok)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic gate_t predict_gate(input logic rs);
        gate_t            g;
        logic [LEN_W-1:0] n;
        frame_t           top;
        int               k;
        int               i;
        int               j;
        bit               ok;
        g = '{'0, '0, 1'b0, 1'b0};
        if (rs)
        begin
            n = size_reg;
            if (n > MAX_WIRES_L)
                n = MAX_WIRES_L;
            walk_depth = '0;
            loop_pos = '0;
            walk_idle = 1'b1;
            if (n > 1)
            begin
                ok = push_walk_frame(KIND_SORT, 0, n, 1'b1);
                walk_idle = 1'b0;
            end
        end
        if (walk_idle || walk_depth == 0)
        begin
            walk_idle = 1'b1;
            g.none = 1'b1;
            return g;
        end
        if (!expand_walk() || walk_depth == 0)
        begin
            walk_depth = '0;
            loop_pos = '0;
            walk_idle = 1'b1;
            g.none = 1'b1;
            return g;
        end
        top = walk_frames[walk_depth - 1];
        k = half_span(int'(top.len));
        i = int'(top.lo) + int'(loop_pos);
        j = i + k;
        if (top.asc)
        begin
            g.min_w = WIRE_W'(i);
            g.max_w = WIRE_W'(j);
        end
        else
        begin
            g.min_w = WIRE_W'(j);
            g.max_w = WIRE_W'(i);
        end
        loop_pos++;
        if (int'(loop_pos) >= int'(top.len) - k)
        begin
            loop_pos = '0;
            walk_depth--;
        end
        if (walk_depth == 0)
        begin
            walk_idle = 1'b1;
            g.fin = 1'b1;
        end
        return g;
    endfunction

    // receiver: random stalls, optional long hold-off
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_ready <= 1'b0;
            holdoff_left--;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_gates.size() == 0)
            begin
                $display("%0t: unexpected transfer min %0d max %0d final %0b none %0b",
                         $time, min_wire, max_wire, final_gate, none_left);
                error_count++;
            end
            else
            begin
                want_gate = expected_gates.pop_front();
                if (min_wire !== want_gate.min_w)
                begin
                    $display("%0t: min_wire expected %0d actual %0d",
                             $time, want_gate.min_w, min_wire);
                    error_count++;
                end
                if (max_wire !== want_gate.max_w)
                begin
                    $display("%0t: max_wire expected %0d actual %0d",
                             $time, want_gate.max_w, max_wire);
                    error_count++;
                end
                if (final_gate !== want_gate.fin)
                begin
                    $display("%0t: final_gate expected %0b actual %0b",
                             $time, want_gate.fin, final_gate);
                    error_count++;
                end
                if (none_left !== want_gate.none)
                begin
                    $display("%0t: none_left expected %0b actual %0b",
                             $time, want_gate.none, none_left);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic rs, output gate_t g);
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        g = predict_gate(rs);
        expected_gates.push_back(g);
        sent_count++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_gates.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_network_size(input logic [LEN_W-1:0] val);
        drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        size_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // optional restart, then requests until the list ends or max_req is reached
    task automatic run_walk(input bit with_restart, input int max_req);
        gate_t g;
        int    cnt;
        cnt = 0;
        g = '{'0, '0, 1'b0, 1'b0};
        if (with_restart)
        begin
            send_request(1'b1, g);
            cnt++;
        end
        while (!(g.fin || g.none) && cnt < max_req)
        begin
            send_request(1'b0, g);
            cnt++;
        end
    endtask

    task automatic test_idle_after_reset();
        gate_t g;
        send_request(1'b0, g);
        send_request(1'b0, g);
        send_request(1'b1, g);
    endtask

    task automatic test_degenerate_sizes();
        gate_t g;
        load_network_size(11'd0);
        send_request(1'b1, g);
        load_network_size(11'd1);
        send_request(1'b1, g);
        send_request(1'b0, g);
        load_network_size(11'd2);
        send_request(1'b1, g);
        send_request(1'b0, g);
        send_request(1'b0, g);
    endtask

    task automatic test_complete_walk();
        gate_t g;
        load_network_size(11'd3);
        run_walk(1'b1, 50);
        send_request(1'b0, g);
    endtask

    task automatic test_size_change_mid_walk();
        load_network_size(11'd4);
        run_walk(1'b1, 2);
        load_network_size(11'd7);
        run_walk(1'b0, 50);
        run_walk(1'b1, 2);
    endtask

    task automatic test_size_saturation();
        load_network_size(11'd2047);
        run_walk(1'b1, 3);
        load_network_size(11'd1025);
        run_walk(1'b1, 2);
        load_network_size(11'd1024);
        run_walk(1'b1, 2);
    endtask

    task automatic test_output_stall();
        load_network_size(11'd16);
        drain_results();
        holdoff_left = 300;
        run_walk(1'b1, 30);
    endtask

    task automatic test_random_walks();
        int               start;
        int               pick;
        int               mode;
        int               i;
        gate_t            g;
        logic [LEN_W-1:0] n;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS)
        begin
            quiet = (sent_count - start < 100);
            pick = $urandom_range(99);
            if (pick < 70)
                n = LEN_W'($urandom_range(2, 20));
            else if (pick < 80)
                n = LEN_W'($urandom_range(0, 1));
            else if (pick < 90)
                n = LEN_W'($urandom_range(21, 64));
            else
                n = LEN_W'($urandom_range(65, 2047));
            load_network_size(n);
            mode = $urandom_range(9);
            if (mode <= 6)
            begin
                run_walk(1'b1, (n > 20) ? $urandom_range(5, 40) : 400);
                repeat ($urandom_range(0, 2)) send_request(1'b0, g);
            end
            else if (mode == 7)
            begin
                run_walk(1'b1, $urandom_range(1, 10));
                run_walk(1'b1, (n > 20) ? 20 : 400);
            end
            else if (mode == 8)
            begin
                for (i = 0; i < 6; i++)
                    send_request($urandom_range(3) == 0, g);
            end
            else
            begin
                run_walk(1'b1, $urandom_range(1, 8));
                load_network_size(LEN_W'($urandom_range(0, 2047)));
                run_walk(1'b0, (n > 20) ? 20 : 400);
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_degenerate_sizes();
        test_complete_walk();
        test_size_change_mid_walk();
        test_size_saturation();
        test_output_stall();
        test_random_walks();

        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bngc_pkg.sv
rtl/core/bitonic_network_comparator_generator.sv
verif/tb.sv
